### design/ftpft_pkg.sv
// ----------------------------------------------------------------------------
// ftpft_pkg
// Shared sizes and the lookup word that walks the chain of table cells.
// ----------------------------------------------------------------------------
package ftpft_pkg;

  localparam int ENTRIES          = 64;
  localparam int PAGE_OFFSET_BITS = 12;
  localparam int ADDR_W           = 32;
  localparam int PAGE_W           = ADDR_W - PAGE_OFFSET_BITS;
  localparam int IDX_W            = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FRAME_W          = 6;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic  active;
    page_t page;
    logic  wr;
    logic  hit;
    logic  newly;
    logic  dirty;
    idx_t  idx;
  } tok_t;

endpackage

### design/first_touch_page_frame_table.sv
// ----------------------------------------------------------------------------
// first_touch_page_frame_table
// Page table that hands out frames in order of first touch, with dirty marks.
// ----------------------------------------------------------------------------
// Each access word walks a chain of ENTRIES cells, one cell per cycle, and
// its result leaves from the register of the last cell. The chain is fully
// pipelined: a new access is taken every cycle, and the whole chain holds
// while a result is stalled at the output, so throughput is one access per
// cycle when the output does not stall. Reset empties the table at once.
module first_touch_page_frame_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ftpft_pkg::ADDR_W-1:0]        in_address,
  input  logic                                in_is_write,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ftpft_pkg::FRAME_W-1:0]       out_frame,
  output logic                                out_newly_mapped,
  output logic                                out_page_dirty,
  output logic                                out_table_full
);

  ftpft_pkg::tok_t tok [ftpft_pkg::ENTRIES+1];
  ftpft_pkg::tok_t head_tok;
  logic            advance;
  ftpft_pkg::tok_t last_tok;

  assign last_tok = tok[ftpft_pkg::ENTRIES];
  assign advance  = !(last_tok.active && out_stall);
  assign in_stall = !advance;

  always_comb begin
    head_tok        = '0;
    head_tok.active = in_valid;
    head_tok.page   = in_address[ftpft_pkg::ADDR_W-1:ftpft_pkg::PAGE_OFFSET_BITS];
    head_tok.wr     = in_is_write;
  end

  assign tok[0] = head_tok;

  for (genvar g = 0; g < ftpft_pkg::ENTRIES; g++) begin : g_cell
    ftpft_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .cell_idx (ftpft_pkg::IDX_W'(g)),
      .tok_in   (tok[g]),
      .tok_r    (tok[g+1])
    );
  end

  assign out_valid        = last_tok.active;
  assign out_frame        = ftpft_pkg::FRAME_W'(last_tok.idx);
  assign out_newly_mapped = last_tok.newly;
  assign out_page_dirty   = last_tok.dirty;
  assign out_table_full   = !last_tok.hit;

endmodule

### design/ftpft_cell.sv
// ----------------------------------------------------------------------------
// ftpft_cell
// One table entry. Compares the passing lookup word with its tag, updates
// its dirty mark on a hit, claims itself when first empty, passes word on.
// ----------------------------------------------------------------------------
module ftpft_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  ftpft_pkg::idx_t   cell_idx,
  input  ftpft_pkg::tok_t   tok_in,
  output ftpft_pkg::tok_t   tok_r
);

  logic             valid_r;
  logic             valid_nxt;
  logic             dirty_r;
  logic             dirty_nxt;
  ftpft_pkg::page_t tag_r;
  ftpft_pkg::page_t tag_nxt;
  ftpft_pkg::tok_t  tok_nxt;

  always_comb begin
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    tag_nxt   = tag_r;
    tok_nxt   = tok_in;
    if (tok_in.active && !tok_in.hit) begin
      if (valid_r && (tag_r == tok_in.page)) begin
        dirty_nxt     = dirty_r | tok_in.wr;
        tok_nxt.hit   = 1'b1;
        tok_nxt.dirty = dirty_r | tok_in.wr;
        tok_nxt.idx   = cell_idx;
      end else if (!valid_r) begin
        // entries fill in order, so the first empty cell is the free frame
        valid_nxt     = 1'b1;
        dirty_nxt     = tok_in.wr;
        tag_nxt       = tok_in.page;
        tok_nxt.hit   = 1'b1;
        tok_nxt.newly = 1'b1;
        tok_nxt.dirty = tok_in.wr;
        tok_nxt.idx   = cell_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      dirty_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else if (advance) begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_r <= tag_nxt;
    end
  end

endmodule

### design/ftpft_checker.sv
// ----------------------------------------------------------------------------
// ftpft_checker
// Port-level checks on the page frame table, bound to the top level.
// ----------------------------------------------------------------------------
module ftpft_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [ftpft_pkg::ADDR_W-1:0]  in_address,
  input logic                          in_is_write,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ftpft_pkg::FRAME_W-1:0] out_frame,
  input logic                          out_newly_mapped,
  input logic                          out_page_dirty,
  input logic                          out_table_full
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_address) && $stable(in_is_write))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_frame) && $stable(out_newly_mapped)
      && $stable(out_page_dirty) && $stable(out_table_full))
    else $error("stalled result word changed");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      !out_newly_mapped && !out_page_dirty && (out_frame == '0))
    else $error("table full result carries a mapping");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind first_touch_page_frame_table ftpft_checker u_ftpft_checker (.*);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-touch page frame table.
// ----------------------------------------------------------------------------
// Access words go in over a valid/stall channel and the predicted frame,
// mapping flag, dirty mark and full flag of each are queued in a scoreboard.
// Every result word taken from the output is checked against the oldest
// prediction. A short directed run covers the address extremes, hits with
// both write flags and the dirty mark sticking. Random words then draw their
// pages from a pool that grows over the run, so the table fills. After that,
// both hits on a full table and new pages refused while it is full occur.
// Sender gaps and receiver stalls vary by phase. One long receiver hold-off
// backs the pipeline up, and a sender pause mid-run lets the table drain.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int POOL_SIZE    = 96;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int QUIET_LIMIT  = 4000;

  typedef struct packed {
    logic [ftpft_pkg::FRAME_W-1:0] frame;
    logic                          newly;
    logic                          dirty;
    logic                          full;
  } frame_result_t;

  class frame_table_scoreboard;
    ftpft_pkg::page_t tag [ftpft_pkg::ENTRIES];
    bit               mapped [ftpft_pkg::ENTRIES];
    bit               dirty [ftpft_pkg::ENTRIES];
    int unsigned      next_frame;
    frame_result_t    expected_q [$];
    int               errors;

    function new();
      for (int i = 0; i < ftpft_pkg::ENTRIES; i++) begin
        tag[i]    = '0;
        mapped[i] = 1'b0;
        dirty[i]  = 1'b0;
      end
      next_frame = 0;
      errors     = 0;
    endfunction

    function void note_access(logic [ftpft_pkg::ADDR_W-1:0] addr, logic wr);
      ftpft_pkg::page_t pg;
      int               hit_idx;
      frame_result_t    r;
      pg      = ftpft_pkg::page_t'(addr >> ftpft_pkg::PAGE_OFFSET_BITS);
      hit_idx = -1;
      for (int i = 0; i < ftpft_pkg::ENTRIES; i++) begin
        if (hit_idx < 0 && mapped[i] && tag[i] == pg) hit_idx = i;
      end
      if (hit_idx >= 0) begin
        dirty[hit_idx] = dirty[hit_idx] | wr;
        r.frame = ftpft_pkg::FRAME_W'(hit_idx);
        r.newly = 1'b0;
        r.dirty = dirty[hit_idx];
        r.full  = 1'b0;
      end else if (next_frame < ftpft_pkg::ENTRIES) begin
        tag[next_frame]    = pg;
        mapped[next_frame] = 1'b1;
        dirty[next_frame]  = wr;
        r.frame = ftpft_pkg::FRAME_W'(next_frame);
        r.newly = 1'b1;
        r.dirty = wr;
        r.full  = 1'b0;
        next_frame++;
      end else begin
        r = '{frame: '0, newly: 1'b0, dirty: 1'b0, full: 1'b1};
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: frame %0d", got.frame);
        errors++;
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      if (got.frame !== want.frame) begin
        $error("frame: expected %0d, got %0d", want.frame, got.frame);
        errors++;
      end
      if (got.newly !== want.newly) begin
        $error("newly_mapped: expected %0b, got %0b", want.newly, got.newly);
        errors++;
      end
      if (got.dirty !== want.dirty) begin
        $error("page_dirty: expected %0b, got %0b", want.dirty, got.dirty);
        errors++;
      end
      if (got.full !== want.full) begin
        $error("table_full: expected %0b, got %0b", want.full, got.full);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [ftpft_pkg::ADDR_W-1:0]  in_address;
  logic                          in_is_write;
  logic                          out_valid;
  logic                          out_stall;
  logic [ftpft_pkg::FRAME_W-1:0] out_frame;
  logic                          out_newly_mapped;
  logic                          out_page_dirty;
  logic                          out_table_full;

  frame_table_scoreboard sb = new();

  int               sender_idle_pct;
  int               receiver_stall_pct;
  bit               hold_req;
  bit               hold_done;
  int               quiet_cycles;
  ftpft_pkg::page_t page_pool [POOL_SIZE];

  first_touch_page_frame_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .in_is_write      (in_is_write),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame        (out_frame),
    .out_newly_mapped (out_newly_mapped),
    .out_page_dirty   (out_page_dirty),
    .out_table_full   (out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // both channels sampled at the same edge, input word noted first
  always @(posedge clk) begin
    if (in_valid && !in_stall) sb.note_access(in_address, in_is_write);
    if (out_valid && !out_stall) begin
      sb.check_result('{frame: out_frame, newly: out_newly_mapped,
                        dirty: out_page_dirty, full: out_table_full});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL first_touch_page_frame_table");
      $finish;
    end
  end

  // receiver, with a long hold-off on request
  initial begin
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic send_access(logic [ftpft_pkg::ADDR_W-1:0] addr, logic wr);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_address  <= addr;
    in_is_write <= wr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int count, int start);
    int                                     window;
    int                                     j;
    logic [ftpft_pkg::PAGE_OFFSET_BITS-1:0] offset;
    for (int k = 0; k < count; k++) begin
      window = 4 + (start + k) / 8;
      if (window > POOL_SIZE - 1) window = POOL_SIZE - 1;
      if ($urandom_range(19) == 0) begin
        send_access($urandom, 1'($urandom_range(1)));
      end else begin
        j      = $urandom_range(window);
        offset = ftpft_pkg::PAGE_OFFSET_BITS'($urandom);
        send_access({page_pool[j], offset}, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_valid           <= 1'b0;
    in_address         <= '0;
    in_is_write        <= 1'b0;
    rst_n              <= 1'b0;
    hold_req           = 1'b0;
    sender_idle_pct    = 16;
    receiver_stall_pct = 88;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = ftpft_pkg::page_t'($urandom);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words: extremes, hits, dirty mark sticking
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'h0000_0FFF, 1'b0);
    send_access(32'h0000_0ABC, 1'b1);
    send_access(32'h0000_0001, 1'b0);
    send_access(32'hFFFF_F000, 1'b0);
    send_access(32'h0000_1000, 1'b0);
    send_access(32'h0000_1ABC, 1'b0);
    send_access(32'h0000_1FFF, 1'b1);
    send_access(32'h8000_0000, 1'b1);
    send_access(32'h7FFF_FFFF, 1'b0);
    send_access(32'hAAAA_AAAA, 1'b1);
    send_access(32'h5555_5555, 1'b0);
    send_access(32'h5555_5000, 1'b1);
    send_access(32'h7FFF_F123, 1'b1);
    send_access(32'h8000_0FFF, 1'b0);
    send_access(32'hFFFF_E000, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'h0000_2000, 1'b1);

    send_random(400, 0);

    // sender pause until the table has answered everything
    wait_drained();
    sender_idle_pct    = 88;
    receiver_stall_pct = 16;
    send_random(400, 400);

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_req           = 1'b1;
    send_random(430, 800);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS first_touch_page_frame_table");
    end else begin
      $display("FAIL first_touch_page_frame_table");
    end
    $finish;
  end

endmodule
